### hw/rtl/isma_pkg.sv
package isma_pkg;

  // Bits of sample_i and sample_q that are used, read as two's complement.
  localparam int SAMPLE_WIDTH = 16;
  // Width of the running sums; they wrap modulo 2**SUM_WIDTH.
  localparam int SUM_WIDTH = 64;

  // Fixed widths of the fields on the ports.
  localparam int FIELD_W = 16;
  localparam int OUT_W   = 64;

  localparam int ENERGY_W = 2 * SAMPLE_WIDTH;
  localparam int STEP_W   = SAMPLE_WIDTH + 2;
  localparam int ROT_W    = 2 * SAMPLE_WIDTH + 1;
  localparam int PEAK_W   = SAMPLE_WIDTH + 1;

  typedef struct packed {
    logic        [ENERGY_W-1:0] energy;
    logic        [STEP_W-1:0]   step;
    logic signed [ROT_W-1:0]    rotation;
    logic        [PEAK_W-1:0]   peak;
  } metrics_t;

endpackage

### hw/rtl/isma_metrics.sv
module isma_metrics (
  input  logic signed [isma_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [isma_pkg::SAMPLE_WIDTH-1:0] sample_q,
  input  logic signed [isma_pkg::SAMPLE_WIDTH-1:0] last_i,
  input  logic signed [isma_pkg::SAMPLE_WIDTH-1:0] last_q,
  input  logic                                     have_last,
  output isma_pkg::metrics_t                       metrics
);
  import isma_pkg::*;

  logic signed [SAMPLE_WIDTH:0]   diff_i;
  logic signed [SAMPLE_WIDTH:0]   diff_q;
  logic signed [SAMPLE_WIDTH:0]   sum_iq;
  logic signed [SAMPLE_WIDTH:0]   dif_iq;
  logic        [SAMPLE_WIDTH:0]   mag_di;
  logic        [SAMPLE_WIDTH:0]   mag_dq;
  logic        [SAMPLE_WIDTH:0]   mag_sum;
  logic        [SAMPLE_WIDTH:0]   mag_dif;
  logic signed [ENERGY_W-1:0]     sq_i;
  logic signed [ENERGY_W-1:0]     sq_q;
  logic signed [ENERGY_W-1:0]     cross_a;
  logic signed [ENERGY_W-1:0]     cross_b;

  always_comb begin
    diff_i = PEAK_W'(sample_i) - PEAK_W'(last_i);
    diff_q = PEAK_W'(sample_q) - PEAK_W'(last_q);
    sum_iq = PEAK_W'(sample_i) + PEAK_W'(sample_q);
    dif_iq = PEAK_W'(sample_i) - PEAK_W'(sample_q);

    // The negation of the most negative value wraps to the same bit pattern,
    // which read unsigned is the correct magnitude.
    mag_di  = diff_i[SAMPLE_WIDTH] ? unsigned'(-diff_i) : unsigned'(diff_i);
    mag_dq  = diff_q[SAMPLE_WIDTH] ? unsigned'(-diff_q) : unsigned'(diff_q);
    mag_sum = sum_iq[SAMPLE_WIDTH] ? unsigned'(-sum_iq) : unsigned'(sum_iq);
    mag_dif = dif_iq[SAMPLE_WIDTH] ? unsigned'(-dif_iq) : unsigned'(dif_iq);

    sq_i    = ENERGY_W'(sample_i) * ENERGY_W'(sample_i);
    sq_q    = ENERGY_W'(sample_q) * ENERGY_W'(sample_q);
    cross_a = ENERGY_W'(last_i) * ENERGY_W'(sample_q);
    cross_b = ENERGY_W'(last_q) * ENERGY_W'(sample_i);

    metrics.energy = unsigned'(sq_i) + unsigned'(sq_q);
    // |I+Q| equals |-I-Q| and |I-Q| equals |-I+Q|, so two candidates remain.
    metrics.peak   = (mag_dif > mag_sum) ? mag_dif : mag_sum;
    if (have_last) begin
      metrics.step     = STEP_W'(mag_di) + STEP_W'(mag_dq);
      metrics.rotation = ROT_W'(cross_a) - ROT_W'(cross_b);
    end else begin
      metrics.step     = '0;
      metrics.rotation = '0;
    end
  end

endmodule

### hw/rtl/iq_sample_metric_accumulator.sv
// IQ sample metric accumulator. Each item on the input stream is one signed
// I/Q pair (tdata) with tlast marking the last pair of a chunk. The block keeps
// five running sums that wrap modulo 2**SUM_WIDTH: energy I*I+Q*Q, the step
// |I-prevI|+|Q-prevQ|, the rotation prevI*Q-prevQ*I, the peak max(|I+Q|,|I-Q|)
// and a pair count. Step and rotation add nothing for the first pair after
// reset. On a pair with tlast set, one result item carrying all five sums,
// that pair included, is presented on the output stream. The block takes one
// item per clock cycle: an input register, a metric register that holds the
// per-pair metrics built from four 16x16 multipliers, and the accumulator
// stage, which loads the output register when a chunk ends. A result is
// presented once its pair has passed the input register, the metric register
// and the accumulator stage into the output register. The input side stalls
// only while a result waits in the output register and the next chunk-ending
// pair waits in the metric register; in every other case pairs keep flowing.
module iq_sample_metric_accumulator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata fields from bit 0 up: sample_i[15:0], sample_q[31:16]
  input  logic [31:0]  s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata fields from bit 0 up: energy_sum[63:0], step_sum[127:64],
  // rotation_sum[191:128], peak_sum[255:192], pair_total[319:256]
  output logic [319:0] m_axis_tdata
);
  import isma_pkg::*;

  // Input register stage.
  logic                           s1_valid;
  logic signed [SAMPLE_WIDTH-1:0] s1_i;
  logic signed [SAMPLE_WIDTH-1:0] s1_q;
  logic                           s1_end;

  // Previous pair, taken when an item leaves the input register.
  logic signed [SAMPLE_WIDTH-1:0] last_i;
  logic signed [SAMPLE_WIDTH-1:0] last_q;
  logic                           have_last;

  // Metric register stage.
  metrics_t                       metrics_now;
  metrics_t                       s2_metrics;
  logic                           s2_valid;
  logic                           s2_end;

  // Accumulators.
  logic [SUM_WIDTH-1:0] energy_acc;
  logic [SUM_WIDTH-1:0] step_acc;
  logic [SUM_WIDTH-1:0] rotation_acc;
  logic [SUM_WIDTH-1:0] peak_acc;
  logic [SUM_WIDTH-1:0] pair_count;
  logic [SUM_WIDTH-1:0] energy_acc_next;
  logic [SUM_WIDTH-1:0] step_acc_next;
  logic [SUM_WIDTH-1:0] rotation_acc_next;
  logic [SUM_WIDTH-1:0] peak_acc_next;
  logic [SUM_WIDTH-1:0] pair_count_next;

  // Output register.
  logic         out_valid;
  logic [319:0] out_data;

  logic s2_fire;
  logic s1_move;
  logic s_take;

  // The accumulator stage may retire an item unless it would overwrite a
  // result that has not yet been taken.
  assign s2_fire       = s2_valid && !(s2_end && out_valid && !m_axis_tready);
  assign s1_move       = s1_valid && (!s2_valid || s2_fire);
  assign s_axis_tready = !s1_valid || s1_move;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (s_take) begin
      s1_i   <= s_axis_tdata[SAMPLE_WIDTH-1:0];
      s1_q   <= s_axis_tdata[FIELD_W+SAMPLE_WIDTH-1:FIELD_W];
      s1_end <= s_axis_tlast;
    end
  end

  isma_metrics u_metrics (
    .sample_i  (s1_i),
    .sample_q  (s1_q),
    .last_i    (last_i),
    .last_q    (last_q),
    .have_last (have_last),
    .metrics   (metrics_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      have_last <= 1'b0;
      last_i    <= '0;
      last_q    <= '0;
    end else begin
      if (s1_move) begin
        s2_valid  <= 1'b1;
        have_last <= 1'b1;
        last_i    <= s1_i;
        last_q    <= s1_q;
      end else if (s2_fire) begin
        s2_valid <= 1'b0;
      end
    end
    if (s1_move) begin
      s2_metrics <= metrics_now;
      s2_end     <= s1_end;
    end
  end

  always_comb begin
    energy_acc_next   = energy_acc + SUM_WIDTH'(s2_metrics.energy);
    step_acc_next     = step_acc + SUM_WIDTH'(s2_metrics.step);
    rotation_acc_next = rotation_acc + unsigned'(SUM_WIDTH'(s2_metrics.rotation));
    peak_acc_next     = peak_acc + SUM_WIDTH'(s2_metrics.peak);
    pair_count_next   = pair_count + SUM_WIDTH'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_acc   <= '0;
      step_acc     <= '0;
      rotation_acc <= '0;
      peak_acc     <= '0;
      pair_count   <= '0;
    end else if (s2_fire) begin
      energy_acc   <= energy_acc_next;
      step_acc     <= step_acc_next;
      rotation_acc <= rotation_acc_next;
      peak_acc     <= peak_acc_next;
      pair_count   <= pair_count_next;
    end
  end

  // Unsigned sums are zero-extended to the port width; the rotation sum is
  // sign-extended from its top bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_fire && s2_end) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (s2_fire && s2_end) begin
      out_data[63:0]    <= OUT_W'(energy_acc_next);
      out_data[127:64]  <= OUT_W'(step_acc_next);
      out_data[191:128] <= unsigned'(OUT_W'(signed'(rotation_acc_next)));
      out_data[255:192] <= OUT_W'(peak_acc_next);
      out_data[319:256] <= OUT_W'(pair_count_next);
    end
  end

  // The input side only stalls behind a result that is waiting downstream.
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (out_valid && !m_axis_tready && s2_valid && s2_end))
    else $error("input stalled without a pending result");

  // Every retired item advances the pair count by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    s2_fire |=> (pair_count == SUM_WIDTH'($past(pair_count) + SUM_WIDTH'(1))))
    else $error("pair count did not advance by one");

  // A new result only appears after a chunk-ending item retired.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s2_fire && s2_end))
    else $error("result appeared without a chunk end");

endmodule
